// ===== hdl/cbd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and address decode functions of the console bus block.
package cbd_pkg;

	// Work RAM size in bytes; must be a power of two so that mirroring is a mask.
	localparam int RAM_DEPTH = 2048;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	// Master ticks per CPU cycle.
	localparam int CPU_DIVIDE = 3;
	localparam int PHASE_W    = $clog2(2 * CPU_DIVIDE);
	localparam int DIV_W      = (CPU_DIVIDE > 1) ? $clog2(CPU_DIVIDE) : 1;
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(2 * CPU_DIVIDE - 1);
	localparam logic [DIV_W-1:0]   DIV_LAST   = DIV_W'(CPU_DIVIDE - 1);

	// Attached device mask bits.
	localparam int DEV_W    = 6;
	localparam int DEV_CPU  = 0;
	localparam int DEV_PPU  = 1;
	localparam int DEV_APU  = 2;
	localparam int DEV_PAD1 = 3;
	localparam int DEV_PAD2 = 4;
	localparam int DEV_CART = 5;
	localparam logic [DEV_W-1:0] DEV_RESET = 6'h3F;

	// Bus addresses with a fixed meaning.
	localparam logic [15:0] ADDR_PPU_BASE   = 16'h2000;
	localparam logic [15:0] ADDR_IO_BASE    = 16'h4000;
	localparam logic [15:0] ADDR_OAM_DMA    = 16'h4014;
	localparam logic [15:0] ADDR_APU_STATUS = 16'h4015;
	localparam logic [15:0] ADDR_PAD1       = 16'h4016;
	localparam logic [15:0] ADDR_PAD2       = 16'h4017;
	localparam logic [15:0] ADDR_CART_BASE  = 16'h4020;

	// Request kinds.
	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2
	} req_t;

	// Bus targets.
	typedef enum logic [2:0] {
		TGT_RAM   = 3'd0,
		TGT_PPU   = 3'd1,
		TGT_APU   = 3'd2,
		TGT_PAD1  = 3'd3,
		TGT_PAD2  = 3'd4,
		TGT_PADS  = 3'd5,
		TGT_CART  = 3'd6,
		TGT_NONE  = 3'd7
	} target_t;

	// Source of the byte returned to the CPU.
	typedef enum logic [1:0] {
		RD_ZERO = 2'd0,
		RD_RAM  = 2'd1,
		RD_EXT  = 2'd2
	} rd_sel_t;

	// How the DMA latch is reloaded after a request.
	typedef enum logic [1:0] {
		LAT_KEEP = 2'd0,
		LAT_RAM  = 2'd1,
		LAT_ZERO = 2'd2
	} latch_op_t;

	// Work RAM port request.
	typedef struct packed {
		logic              we;
		logic [RAM_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [RAM_AW-1:0] raddr;
	} ram_req_t;

	// Decoded request held between the input and the output register.
	typedef struct packed {
		target_t    target;
		logic [15:0] fwd_address;
		logic [7:0] fwd_data;
		logic       fwd_from_latch;
		rd_sel_t    rd_sel;
		logic [7:0] ext_data;
		logic       latch_ext;
		latch_op_t  latch_op;
		logic       ppu_tick;
		logic       cpu_tick;
		logic       apu_tick;
		logic       oam_write;
		logic [7:0] oam_index;
		logic       dma_busy;
		logic       nmi_to_cpu;
	} s1_t;

	// Finished result.
	typedef struct packed {
		target_t     target;
		logic [7:0]  read_data;
		logic [15:0] fwd_address;
		logic [7:0]  fwd_data;
		logic        ppu_tick;
		logic        cpu_tick;
		logic        apu_tick;
		logic        oam_write;
		logic [7:0]  oam_index;
		logic        dma_busy;
		logic        nmi_to_cpu;
	} res_t;

	// Target of a CPU or DMA read.
	function automatic target_t read_target(input logic [15:0] a, input logic [DEV_W-1:0] dev);
		target_t t;
		if (a < ADDR_PPU_BASE) begin
			t = TGT_RAM;
		end else if (a < ADDR_IO_BASE) begin
			t = dev[DEV_PPU] ? TGT_PPU : TGT_NONE;
		end else if (a == ADDR_APU_STATUS) begin
			t = dev[DEV_APU] ? TGT_APU : TGT_NONE;
		end else if (a == ADDR_PAD1) begin
			t = dev[DEV_PAD1] ? TGT_PAD1 : TGT_NONE;
		end else if (a == ADDR_PAD2) begin
			t = dev[DEV_PAD2] ? TGT_PAD2 : TGT_NONE;
		end else if (a < ADDR_CART_BASE) begin
			t = TGT_NONE;
		end else begin
			t = dev[DEV_CART] ? TGT_CART : TGT_NONE;
		end
		return t;
	endfunction

	// Target of a CPU write.
	function automatic target_t write_target(input logic [15:0] a, input logic [DEV_W-1:0] dev);
		target_t t;
		if (a < ADDR_PPU_BASE) begin
			t = TGT_RAM;
		end else if (a < ADDR_IO_BASE) begin
			t = dev[DEV_PPU] ? TGT_PPU : TGT_NONE;
		end else if (a == ADDR_OAM_DMA) begin
			t = TGT_NONE;
		end else if (a == ADDR_PAD1) begin
			if (dev[DEV_PAD1] && dev[DEV_PAD2]) begin
				t = TGT_PADS;
			end else if (dev[DEV_PAD1]) begin
				t = TGT_PAD1;
			end else if (dev[DEV_PAD2]) begin
				t = TGT_PAD2;
			end else begin
				t = TGT_NONE;
			end
		end else if (a < ADDR_CART_BASE) begin
			t = dev[DEV_APU] ? TGT_APU : TGT_NONE;
		end else begin
			t = dev[DEV_CART] ? TGT_CART : TGT_NONE;
		end
		return t;
	endfunction

endpackage

// ===== hdl/cpu_bus_decode_oam_dma.sv =====
`timescale 1ns / 1ps
// Top level of the console CPU bus decoder with work RAM and sprite DMA.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    req_type, address, write_data, ext_data, ppu_nmi
//   out      out_valid / out_stall  target, read_data, fwd_address, fwd_data, ticks,
//                                   oam_write, oam_index, dma_busy, nmi_to_cpu
//   cfg      cfg_we                 cfg_wdata (attached device mask)
//
// One request is taken per clock while in_stall is low; its result passes through the
// decode register (work RAM read issued) and then the output register.
// After reset the work RAM is cleared one byte per cycle, all RAM_DEPTH (2048) bytes,
// with in_stall held high; configuration writes are taken during that time.
// A stall on the output holds the result and backs up into in_stall only once
// both registers are full.
module cpu_bus_decode_oam_dma import cbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DEV_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [15:0]      address,
	input  logic [7:0]       write_data,
	input  logic [7:0]       ext_data,
	input  logic             ppu_nmi,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       target,
	output logic [7:0]       read_data,
	output logic [15:0]      fwd_address,
	output logic [7:0]       fwd_data,
	output logic             ppu_tick,
	output logic             cpu_tick,
	output logic             apu_tick,
	output logic             oam_write,
	output logic [7:0]       oam_index,
	output logic             dma_busy,
	output logic             nmi_to_cpu
);

	logic [DEV_W-1:0] dev_q;
	logic             s1_valid, s1_adv;
	s1_t              s1;
	ram_req_t         ram_req;
	logic [7:0]       ram_rdata;
	res_t             res;

	// Attached device mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= DEV_RESET;
		end else if (cfg_we) begin
			dev_q <= cfg_wdata;
		end
	end

	// Request decode and DMA sequencing.
	cbd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.address    (address),
		.write_data (write_data),
		.ext_data   (ext_data),
		.ppu_nmi    (ppu_nmi),
		.dev        (dev_q),
		.s1_adv     (s1_adv),
		.s1_valid   (s1_valid),
		.s1         (s1),
		.ram_req    (ram_req)
	);

	// Work RAM.
	cbd_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// Result selection and output register.
	cbd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1        (s1),
		.ram_rdata (ram_rdata),
		.s1_adv    (s1_adv),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res)
	);

	assign target      = res.target;
	assign read_data   = res.read_data;
	assign fwd_address = res.fwd_address;
	assign fwd_data    = res.fwd_data;
	assign ppu_tick    = res.ppu_tick;
	assign cpu_tick    = res.cpu_tick;
	assign apu_tick    = res.apu_tick;
	assign oam_write   = res.oam_write;
	assign oam_index   = res.oam_index;
	assign dma_busy    = res.dma_busy;
	assign nmi_to_cpu  = res.nmi_to_cpu;

endmodule

// ===== hdl/cbd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module cbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/cbd_ctrl.sv =====
`timescale 1ns / 1ps
// Request decode, tick divider, sprite DMA sequencer and RAM clearing pass.
module cbd_ctrl import cbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [15:0]      address,
	input  logic [7:0]       write_data,
	input  logic [7:0]       ext_data,
	input  logic             ppu_nmi,
	input  logic [DEV_W-1:0] dev,
	input  logic             s1_adv,
	output logic             s1_valid,
	output s1_t              s1,
	output ram_req_t         ram_req
);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [DIV_W-1:0]   div_q, div_d;
	logic [7:0]         page_q, page_d;
	logic [7:0]         index_q, index_d;
	logic               active_q, active_d;
	logic               sync_q, sync_d;
	logic               src_ext_q, src_ext_d;
	logic               clr_busy_q;
	logic [RAM_AW-1:0]  clr_addr_q;
	logic               s1_valid_q;
	s1_t                s1_s1, s1_d;
	logic               acc;
	target_t            rd_tgt, src_tgt;
	logic [15:0]        src_addr;
	logic [7:0]         index_inc;
	logic               ram_we, ram_re;
	logic [RAM_AW-1:0]  ram_raddr;

	// Input handshake: hold off during the clear and while the decode register is full and cannot move on.
	assign in_stall = clr_busy_q || (s1_valid_q && !s1_adv);
	assign acc      = in_valid && !in_stall;

	assign src_addr  = {page_q, index_q};
	assign src_tgt   = read_target(src_addr, dev);
	assign rd_tgt    = read_target(address, dev);
	assign index_inc = index_q + 8'd1;

	// Decode of one request and next DMA / divider state.
	always_comb begin
		phase_d   = phase_q;
		div_d     = div_q;
		page_d    = page_q;
		index_d   = index_q;
		active_d  = active_q;
		sync_d    = sync_q;
		src_ext_d = src_ext_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = address[RAM_AW-1:0];
		s1_d          = '0;
		s1_d.target   = TGT_NONE;
		s1_d.rd_sel   = RD_ZERO;
		s1_d.latch_op = LAT_KEEP;
		s1_d.ext_data = ext_data;
		case (req_type)
			REQ_READ: begin
				s1_d.target      = rd_tgt;
				s1_d.fwd_address = address;
				if (rd_tgt == TGT_RAM) begin
					s1_d.rd_sel = RD_RAM;
					ram_re      = 1'b1;
				end else if (rd_tgt != TGT_NONE) begin
					s1_d.rd_sel = RD_EXT;
				end
			end
			REQ_WRITE: begin
				s1_d.target      = write_target(address, dev);
				s1_d.fwd_address = address;
				s1_d.fwd_data    = write_data;
				if (address < ADDR_PPU_BASE) begin
					ram_we = 1'b1;
				end else if (address == ADDR_OAM_DMA) begin
					page_d   = write_data;
					index_d  = 8'd0;
					active_d = 1'b1;
					sync_d   = 1'b1;
				end
			end
			REQ_TICK: begin
				// A byte from an external DMA source arrives on the tick after its read.
				if (src_ext_q) begin
					s1_d.latch_ext = 1'b1;
					src_ext_d      = 1'b0;
				end
				s1_d.ppu_tick = dev[DEV_PPU];
				if (div_q == '0) begin
					if (active_q) begin
						if (sync_q) begin
							if (phase_q[0]) begin
								sync_d = 1'b0;
							end
						end else if (!phase_q[0]) begin
							s1_d.target      = src_tgt;
							s1_d.fwd_address = src_addr;
							if (src_tgt == TGT_RAM) begin
								s1_d.latch_op = LAT_RAM;
								ram_re        = 1'b1;
								ram_raddr     = src_addr[RAM_AW-1:0];
							end else if (src_tgt == TGT_NONE) begin
								s1_d.latch_op = LAT_ZERO;
							end else begin
								src_ext_d = 1'b1;
							end
						end else begin
							if (dev[DEV_PPU]) begin
								s1_d.target    = TGT_PPU;
								s1_d.oam_write = 1'b1;
							end
							s1_d.fwd_from_latch = 1'b1;
							s1_d.oam_index      = index_q;
							index_d             = index_inc;
							if (index_inc == 8'd0) begin
								active_d = 1'b0;
							end
						end
					end else begin
						s1_d.cpu_tick = dev[DEV_CPU];
					end
					s1_d.apu_tick = dev[DEV_APU];
				end
				s1_d.nmi_to_cpu = ppu_nmi && dev[DEV_CPU] && dev[DEV_PPU];
				phase_d = (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
				div_d   = (div_q == DIV_LAST) ? '0 : div_q + 1'b1;
			end
			default: begin
			end
		endcase
		s1_d.dma_busy = active_d;
	end

	// RAM port: the clearing pass owns the write side until it is done.
	always_comb begin
		ram_req       = '0;
		ram_req.re    = acc && ram_re;
		ram_req.raddr = ram_raddr;
		if (clr_busy_q) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = clr_addr_q;
			ram_req.wdata = 8'd0;
		end else begin
			ram_req.we    = acc && ram_we;
			ram_req.waddr = address[RAM_AW-1:0];
			ram_req.wdata = write_data;
		end
	end

	// Bus state, updated once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			div_q     <= '0;
			page_q    <= 8'd0;
			index_q   <= 8'd0;
			active_q  <= 1'b0;
			sync_q    <= 1'b0;
			src_ext_q <= 1'b0;
		end else if (acc) begin
			phase_q   <= phase_d;
			div_q     <= div_d;
			page_q    <= page_d;
			index_q   <= index_d;
			active_q  <= active_d;
			sync_q    <= sync_d;
			src_ext_q <= src_ext_d;
		end
	end

	// Clearing pass over the work RAM after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Decode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_s1 <= s1_d;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1       = s1_s1;

endmodule

// ===== hdl/cbd_out.sv =====
`timescale 1ns / 1ps
// Data selection, DMA latch and output register of the console bus block.
module cbd_out import cbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s1_valid,
	input  s1_t        s1,
	input  logic [7:0] ram_rdata,
	output logic       s1_adv,
	input  logic       out_stall,
	output logic       out_valid,
	output res_t       res
);

	logic       out_valid_q;
	res_t       res_q, res_d;
	logic [7:0] latch_q, latch_pre, latch_d;

	// The decode register moves on whenever the output register is free or taken.
	assign s1_adv = s1_valid && (!out_valid_q || !out_stall);

	// Latch value seen by this request, and the value it leaves behind.
	always_comb begin
		latch_pre = s1.latch_ext ? s1.ext_data : latch_q;
		case (s1.latch_op)
			LAT_RAM:  latch_d = ram_rdata;
			LAT_ZERO: latch_d = 8'd0;
			default:  latch_d = latch_pre;
		endcase
	end

	// Result assembly.
	always_comb begin
		res_d.target      = s1.target;
		res_d.fwd_address = s1.fwd_address;
		res_d.fwd_data    = s1.fwd_from_latch ? latch_pre : s1.fwd_data;
		res_d.ppu_tick    = s1.ppu_tick;
		res_d.cpu_tick    = s1.cpu_tick;
		res_d.apu_tick    = s1.apu_tick;
		res_d.oam_write   = s1.oam_write;
		res_d.oam_index   = s1.oam_index;
		res_d.dma_busy    = s1.dma_busy;
		res_d.nmi_to_cpu  = s1.nmi_to_cpu;
		case (s1.rd_sel)
			RD_RAM:  res_d.read_data = ram_rdata;
			RD_EXT:  res_d.read_data = s1.ext_data;
			default: res_d.read_data = 8'd0;
		endcase
	end

	// DMA latch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 8'd0;
		end else if (s1_adv) begin
			latch_q <= latch_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the console CPU bus decoder with work RAM and sprite DMA.
import cbd_pkg::*;

// Tracks bus and sprite DMA state, predicts each result and checks it on arrival.
class bus_tracker;
	logic [DEV_W-1:0] device_mask;
	logic [7:0]       ram_copy[RAM_DEPTH];
	int               phase;
	logic [7:0]       page;
	logic [7:0]       index;
	bit               dma_on;
	bit               dma_sync;
	logic [7:0]       latch;
	bit               byte_due;
	res_t             pending_results[$];
	int               mismatches;

	function new();
		device_mask = DEV_RESET;
		foreach (ram_copy[i]) ram_copy[i] = 8'h00;
		phase = 0;
		page = 8'h00;
		index = 8'h00;
		dma_on = 1'b0;
		dma_sync = 1'b0;
		latch = 8'h00;
		byte_due = 1'b0;
		mismatches = 0;
	endfunction

	// Device hit by a read from the CPU or from the DMA engine.
	function target_t read_dest(logic [15:0] a);
		target_t t;
		t = TGT_NONE;
		if (a < ADDR_PPU_BASE) begin
			t = TGT_RAM;
		end else if (a < ADDR_IO_BASE) begin
			if (device_mask[DEV_PPU]) t = TGT_PPU;
		end else if (a >= ADDR_CART_BASE) begin
			if (device_mask[DEV_CART]) t = TGT_CART;
		end else begin
			case (a)
			ADDR_APU_STATUS: if (device_mask[DEV_APU]) t = TGT_APU;
			ADDR_PAD1: if (device_mask[DEV_PAD1]) t = TGT_PAD1;
			ADDR_PAD2: if (device_mask[DEV_PAD2]) t = TGT_PAD2;
			default: ;
			endcase
		end
		return t;
	endfunction

	// Device hit by a CPU write; the controller strobe reaches every pad present.
	function target_t write_dest(logic [15:0] a);
		target_t t;
		t = TGT_NONE;
		if (a < ADDR_PPU_BASE) begin
			t = TGT_RAM;
		end else if (a < ADDR_IO_BASE) begin
			if (device_mask[DEV_PPU]) t = TGT_PPU;
		end else if (a >= ADDR_CART_BASE) begin
			if (device_mask[DEV_CART]) t = TGT_CART;
		end else if (a == ADDR_PAD1) begin
			case ({device_mask[DEV_PAD2], device_mask[DEV_PAD1]})
			2'b11: t = TGT_PADS;
			2'b01: t = TGT_PAD1;
			2'b10: t = TGT_PAD2;
			default: t = TGT_NONE;
			endcase
		end else if (a != ADDR_OAM_DMA) begin
			if (device_mask[DEV_APU]) t = TGT_APU;
		end
		return t;
	endfunction

	// Applies one accepted request and queues the result it must produce.
	function void note_request(logic [1:0] kind, logic [15:0] a, logic [7:0] wd,
			logic [7:0] ext, logic nmi);
		res_t        r;
		logic [15:0] src;
		target_t     t;
		bit          odd;
		r = '0;
		r.target = TGT_NONE;
		case (kind)
		REQ_READ: begin
			t = read_dest(a);
			r.target = t;
			r.fwd_address = a;
			if (t == TGT_RAM) r.read_data = ram_copy[a % RAM_DEPTH];
			else if (t != TGT_NONE) r.read_data = ext;
		end
		REQ_WRITE: begin
			r.target = write_dest(a);
			r.fwd_address = a;
			r.fwd_data = wd;
			if (a < ADDR_PPU_BASE) begin
				ram_copy[a % RAM_DEPTH] = wd;
			end else if (a == ADDR_OAM_DMA) begin
				page = wd;
				index = 8'h00;
				dma_on = 1'b1;
				dma_sync = 1'b1;
			end
		end
		REQ_TICK: begin
			odd = (phase % 2) == 1;
			// A byte fetched from an external device arrives one tick after its read.
			if (byte_due) begin
				latch = ext;
				byte_due = 1'b0;
			end
			r.ppu_tick = device_mask[DEV_PPU];
			if (phase % CPU_DIVIDE == 0) begin
				if (!dma_on) begin
					r.cpu_tick = device_mask[DEV_CPU];
				end else if (dma_sync) begin
					if (odd) dma_sync = 1'b0;
				end else if (!odd) begin
					src = {page, index};
					t = read_dest(src);
					r.target = t;
					r.fwd_address = src;
					if (t == TGT_RAM) latch = ram_copy[src % RAM_DEPTH];
					else if (t == TGT_NONE) latch = 8'h00;
					else byte_due = 1'b1;
				end else begin
					if (device_mask[DEV_PPU]) begin
						r.target = TGT_PPU;
						r.oam_write = 1'b1;
					end
					r.fwd_data = latch;
					r.oam_index = index;
					index++;
					if (index == 8'h00) dma_on = 1'b0;
				end
				r.apu_tick = device_mask[DEV_APU];
			end
			r.nmi_to_cpu = nmi & device_mask[DEV_CPU] & device_mask[DEV_PPU];
			phase = (phase + 1) % (2 * CPU_DIVIDE);
		end
		default: ;
		endcase
		r.dma_busy = dma_on;
		pending_results.push_back(r);
	endfunction

	function string show(res_t r);
		return $sformatf({"target=%0d read=%02h addr=%04h data=%02h ppu/cpu/apu=%0b%0b%0b",
			" oam=%0b idx=%02h busy=%0b nmi=%0b"}, r.target, r.read_data, r.fwd_address,
			r.fwd_data, r.ppu_tick, r.cpu_tick, r.apu_tick, r.oam_write, r.oam_index,
			r.dma_busy, r.nmi_to_cpu);
	endfunction

	// Compares one delivered result with the oldest prediction.
	function void check_result(res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("ERROR: result with no request waiting: %s", show(got));
			return;
		end
		want = pending_results.pop_front();
		if (got.target !== want.target || got.read_data !== want.read_data ||
				got.fwd_address !== want.fwd_address || got.fwd_data !== want.fwd_data ||
				got.ppu_tick !== want.ppu_tick || got.cpu_tick !== want.cpu_tick ||
				got.apu_tick !== want.apu_tick || got.oam_write !== want.oam_write ||
				got.oam_index !== want.oam_index || got.dma_busy !== want.dma_busy ||
				got.nmi_to_cpu !== want.nmi_to_cpu) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: result mismatch");
				$display("  expected %s", show(want));
				$display("  actual   %s", show(got));
			end
		end
	endfunction
endclass

module testbench;
	localparam int CLOCK_LIMIT = 400000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [DEV_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       req_type;
	logic [15:0]      address;
	logic [7:0]       write_data;
	logic [7:0]       ext_data;
	logic             ppu_nmi;
	logic             out_valid;
	logic             out_stall;
	logic [2:0]       target;
	logic [7:0]       read_data;
	logic [15:0]      fwd_address;
	logic [7:0]       fwd_data;
	logic             ppu_tick;
	logic             cpu_tick;
	logic             apu_tick;
	logic             oam_write;
	logic [7:0]       oam_index;
	logic             dma_busy;
	logic             nmi_to_cpu;

	int         send_idle;
	int         recv_idle;
	int         cycles;
	int         mode;
	int         seg;
	res_t       seen;
	bus_tracker sb;

	cpu_bus_decode_oam_dma uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.address(address),
		.write_data(write_data),
		.ext_data(ext_data),
		.ppu_nmi(ppu_nmi),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.target(target),
		.read_data(read_data),
		.fwd_address(fwd_address),
		.fwd_data(fwd_data),
		.ppu_tick(ppu_tick),
		.cpu_tick(cpu_tick),
		.apu_tick(apu_tick),
		.oam_write(oam_write),
		.oam_index(oam_index),
		.dma_busy(dma_busy),
		.nmi_to_cpu(nmi_to_cpu)
	);

	always #5 clk = ~clk;

	// Run time guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CLOCK_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side stalls at random.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Every delivered result is checked against the prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.target = target_t'(target);
			seen.read_data = read_data;
			seen.fwd_address = fwd_address;
			seen.fwd_data = fwd_data;
			seen.ppu_tick = ppu_tick;
			seen.cpu_tick = cpu_tick;
			seen.apu_tick = apu_tick;
			seen.oam_write = oam_write;
			seen.oam_index = oam_index;
			seen.dma_busy = dma_busy;
			seen.nmi_to_cpu = nmi_to_cpu;
			sb.check_result(seen);
		end
	end

	// Presents one request, with random idle cycles ahead of it, and waits until it is taken.
	task automatic send(input logic [1:0] kind, input logic [15:0] a, input logic [7:0] wd);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		req_type <= kind;
		address <= a;
		write_data <= wd;
		ext_data <= 8'($urandom);
		ppu_nmi <= 1'($urandom);
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(kind, a, wd, ext_data, ppu_nmi);
	endtask

	// Stops sending and waits for every predicted result to come back.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Changes the attached device mask while the bus is quiet.
	task automatic set_devices(input logic [DEV_W-1:0] mask);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mask;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.device_mask = mask;
	endtask

	// Address spread over RAM, picture registers, I/O registers and the cartridge space.
	function automatic logic [15:0] pick_address();
		case ($urandom_range(5))
		0, 1: return 16'($urandom_range(16'h1FFF));
		2: return 16'($urandom_range(16'h3FFF, 16'h2000));
		3: return 16'($urandom_range(16'h401F, 16'h4000));
		4: return 16'($urandom_range(16'hFFFF, 16'h4020));
		default: return 16'($urandom);
		endcase
	endfunction

	// Mostly ticks, reads and writes; sprite DMA starts and undefined requests are rare.
	task automatic random_request();
		int          roll;
		logic [15:0] a;
		roll = $urandom_range(99);
		a = pick_address();
		if (roll < 45) begin
			send(REQ_TICK, a, 8'($urandom));
		end else if (roll < 70) begin
			send(REQ_READ, a, 8'($urandom));
		end else if (roll < 97) begin
			if (a == ADDR_OAM_DMA) a = ADDR_PAD1;
			send(REQ_WRITE, a, 8'($urandom));
		end else if (roll < 98) begin
			send(REQ_WRITE, ADDR_OAM_DMA, 8'($urandom));
		end else begin
			send(REQ_UNUSED, a, 8'($urandom));
		end
	endtask

	// Runs one sprite DMA to the end with CPU accesses mixed in.
	task automatic full_dma(input logic [7:0] src_page);
		logic [15:0] a;
		send(REQ_WRITE, ADDR_OAM_DMA, src_page);
		while (sb.dma_on) begin
			if ($urandom_range(7) == 0) begin
				a = pick_address();
				if (a == ADDR_OAM_DMA) a = ADDR_PPU_BASE;
				if ($urandom_range(1) == 1) send(REQ_WRITE, a, 8'($urandom));
				else send(REQ_READ, a, 8'($urandom));
			end else begin
				send(REQ_TICK, 16'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req_type = '0;
		address = '0;
		write_data = '0;
		ext_data = '0;
		ppu_nmi = 1'b0;
		out_stall = 1'b0;
		send_idle = 23;
		recv_idle = 85;
		cycles = 0;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: decode edges, RAM mirroring, unmapped I/O, undefined request.
		set_devices(DEV_RESET);
		send(REQ_WRITE, 16'h0000, 8'hFF);
		send(REQ_WRITE, 16'h07FF, 8'h5A);
		send(REQ_READ, 16'h0800, 8'h00);
		send(REQ_READ, 16'h1FFF, 8'h00);
		send(REQ_READ, 16'h0001, 8'h00);
		send(REQ_WRITE, ADDR_PPU_BASE, 8'h80);
		send(REQ_READ, 16'h3FFF, 8'h00);
		send(REQ_WRITE, ADDR_IO_BASE, 8'h11);
		send(REQ_READ, ADDR_IO_BASE, 8'h00);
		send(REQ_READ, ADDR_OAM_DMA, 8'h00);
		send(REQ_READ, ADDR_APU_STATUS, 8'h00);
		send(REQ_READ, ADDR_PAD1, 8'h00);
		send(REQ_READ, ADDR_PAD2, 8'h00);
		send(REQ_READ, 16'h401F, 8'h00);
		send(REQ_WRITE, 16'h401F, 8'h22);
		send(REQ_WRITE, ADDR_PAD1, 8'h01);
		send(REQ_READ, ADDR_CART_BASE, 8'h00);
		send(REQ_WRITE, 16'hFFFF, 8'hAA);
		send(REQ_READ, 16'hFFFF, 8'h00);
		send(REQ_UNUSED, 16'hFFFF, 8'hFF);
		// DMA start, then a restart while it runs.
		send(REQ_WRITE, ADDR_OAM_DMA, 8'h07);
		repeat (12) send(REQ_TICK, 16'hFFFF, 8'hFF);
		send(REQ_WRITE, ADDR_OAM_DMA, 8'h00);
		repeat (12) send(REQ_TICK, 16'h0000, 8'h00);
		// Controller strobe with a single pad, and absent devices.
		set_devices(DEV_W'(1 << DEV_PAD1));
		send(REQ_WRITE, ADDR_PAD1, 8'h01);
		set_devices(DEV_W'(1 << DEV_PAD2));
		send(REQ_WRITE, ADDR_PAD1, 8'h00);
		set_devices('0);
		send(REQ_READ, ADDR_PPU_BASE, 8'h00);
		send(REQ_READ, ADDR_APU_STATUS, 8'h00);
		send(REQ_READ, ADDR_CART_BASE, 8'h00);
		send(REQ_TICK, 16'h0000, 8'h00);

		// Random traffic under three idling patterns and several device masks.
		for (mode = 0; mode < 3; mode++) begin
			case (mode)
			0: begin
				send_idle = 23;
				recv_idle = 85;
			end
			1: begin
				send_idle = 85;
				recv_idle = 23;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
			endcase
			for (seg = 0; seg < 4; seg++) begin
				if (seg == 0) set_devices(DEV_RESET);
				else if (seg == 1) set_devices('0);
				else set_devices(DEV_W'($urandom));
				repeat (25) random_request();
			end
		end

		// One sprite DMA carried through to the index wrap.
		set_devices(DEV_RESET);
		if ($urandom_range(1) == 1) full_dma(8'($urandom_range(8'h1F)));
		else full_dma(8'($urandom));

		settle();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/cbd_pkg.sv
hdl/cbd_ram.sv
hdl/cbd_ctrl.sv
hdl/cbd_out.sv
hdl/cpu_bus_decode_oam_dma.sv
test/testbench.sv
